// ===== rtl/u16550_pkg.sv =====
// Shared types and constants for the 16550-style UART register block.
package u16550_pkg;

   localparam logic [1:0] OP_BUS_READ  = 2'd0;
   localparam logic [1:0] OP_BUS_WRITE = 2'd1;
   localparam logic [1:0] OP_RX_BYTE   = 2'd2;

   localparam logic [2:0] REG_RHR_THR = 3'd0;
   localparam logic [2:0] REG_IER     = 3'd1;
   localparam logic [2:0] REG_IIR_FCR = 3'd2;
   localparam logic [2:0] REG_LCR     = 3'd3;
   localparam logic [2:0] REG_MCR     = 3'd4;
   localparam logic [2:0] REG_LSR     = 3'd5;
   localparam logic [2:0] REG_MSR     = 3'd6;
   localparam logic [2:0] REG_SCR     = 3'd7;

   localparam logic [7:0] MCR_RESET   = 8'h08;
   localparam logic [7:0] MSR_RESET   = 8'hB0;
   localparam logic [7:0] IIR_FIFO_ON = 8'hC0;
   localparam logic [7:0] IIR_ID_RX   = 8'h04;
   localparam logic [7:0] IIR_ID_THRE = 8'h02;
   localparam logic [7:0] IIR_ID_NONE = 8'h01;
   localparam logic [7:0] LSR_IDLE    = 8'h60;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   localparam int LCR_DLAB_BIT     = 7;
   localparam int MCR_LOOPBACK_BIT = 4;
   localparam int FCR_ENABLE_BIT   = 0;
   localparam int IER_RX_BIT       = 0;
   localparam int IER_THRE_BIT     = 1;

   typedef struct packed {
      logic load_item;
      logic execute;
   } ctl_cmd_type;

endpackage

// ===== rtl/u16550_dpath.sv =====
// Datapath: UART registers, RX FIFO memory, item and result registers.
module u16550_dpath #(
   parameter int RX_FIFO_DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  u16550_pkg::ctl_cmd_type  cmd,
   input  logic [1:0]               req_opcode,
   input  logic [2:0]               req_reg_offset,
   input  logic [7:0]               req_data_byte,
   input  logic                     csr_wr_en,
   input  logic                     csr_wr_data,
   output logic [7:0]               rsp_read_data,
   output logic                     rsp_tx_valid,
   output logic [7:0]               rsp_tx_byte,
   output logic                     rsp_irq,
   output logic                     rsp_rx_dropped
);
   import u16550_pkg::*;

   localparam int PTR_W = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RX_FIFO_DEPTH - 1);

   logic [7:0] rx_mem [RX_FIFO_DEPTH];
   logic [7:0] mem_rd_ff;

   logic [1:0] op_ff;
   logic [2:0] off_ff;
   logic [7:0] data_ff;

   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [7:0] lcr_ff, lcr_in, mcr_ff, mcr_in, fcr_ff, fcr_in, scr_ff, scr_in;
   logic [7:0] msr_ff, msr_in, dll_ff, dll_in, dlm_ff, dlm_in;
   logic [3:0] ier_ff, ier_in;
   logic       txp_ff, txp_in;
   logic       lf_cr_ff, lf_cr_in;

   logic [7:0] rd_in, txb_in, rx_byte;
   logic       txv_in, drop_in, irq_in, push;

   logic [PTR_W-1:0] head_nxt, tail_nxt;
   logic             dlab, nonempty, full;
   logic [7:0]       kind;

   assign head_nxt = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
   assign tail_nxt = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
   assign nonempty = head_ff != tail_ff;
   assign full     = tail_nxt == head_ff;
   assign dlab     = lcr_ff[LCR_DLAB_BIT];
   assign kind     = fcr_ff[FCR_ENABLE_BIT] ? IIR_FIFO_ON : 8'h00;
   assign rx_byte  = (lf_cr_ff && data_ff == CHAR_LF) ? CHAR_CR : data_ff;
   assign lf_cr_in = csr_wr_en ? csr_wr_data : lf_cr_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      lcr_in  = lcr_ff;
      mcr_in  = mcr_ff;
      fcr_in  = fcr_ff;
      scr_in  = scr_ff;
      msr_in  = msr_ff;
      dll_in  = dll_ff;
      dlm_in  = dlm_ff;
      ier_in  = ier_ff;
      txp_in  = txp_ff;
      rd_in   = 8'h00;
      txv_in  = 1'b0;
      txb_in  = 8'h00;
      drop_in = 1'b0;
      push    = 1'b0;
      if (cmd.execute) begin
         case (op_ff)
            OP_RX_BYTE: begin
               if (full) begin
                  drop_in = 1'b1;
               end else begin
                  push    = 1'b1;
                  tail_in = tail_nxt;
               end
            end
            OP_BUS_WRITE: begin
               case (off_ff)
                  REG_RHR_THR: begin
                     if (dlab) begin
                        dll_in = data_ff;
                     end else if (!mcr_ff[MCR_LOOPBACK_BIT]) begin
                        txv_in = 1'b1;
                        txb_in = data_ff;
                        txp_in = 1'b1;
                     end
                  end
                  REG_IER: begin
                     if (dlab) dlm_in = data_ff;
                     else      ier_in = data_ff[3:0];
                  end
                  REG_IIR_FCR: fcr_in = data_ff;
                  REG_LCR:     lcr_in = data_ff;
                  REG_MCR:     mcr_in = data_ff;
                  REG_MSR:     msr_in = data_ff;
                  REG_SCR:     scr_in = data_ff;
                  default: ;
               endcase
            end
            OP_BUS_READ: begin
               case (off_ff)
                  REG_RHR_THR: begin
                     if (dlab) begin
                        rd_in = dll_ff;
                     end else if (nonempty) begin
                        rd_in   = mem_rd_ff;
                        head_in = head_nxt;
                     end
                  end
                  REG_IER: rd_in = dlab ? dlm_ff : {4'h0, ier_ff};
                  REG_IIR_FCR: begin
                     if (ier_ff[IER_RX_BIT] && nonempty) begin
                        rd_in = IIR_ID_RX | kind;
                     end else if (ier_ff[IER_THRE_BIT] && txp_ff) begin
                        rd_in  = IIR_ID_THRE | kind;
                        txp_in = 1'b0;
                     end else begin
                        rd_in = IIR_ID_NONE | kind;
                     end
                  end
                  REG_LCR: rd_in = lcr_ff;
                  REG_MCR: rd_in = mcr_ff;
                  REG_LSR: rd_in = LSR_IDLE | {7'd0, nonempty};
                  REG_MSR: rd_in = msr_ff;
                  default: rd_in = scr_ff;
               endcase
            end
            default: ;
         endcase
      end
      irq_in = (ier_in[IER_RX_BIT] && (head_in != tail_in)) ||
               (ier_in[IER_THRE_BIT] && txp_in);
   end

   always_ff @(posedge clock) begin
      if (push) rx_mem[tail_ff] <= rx_byte;
      mem_rd_ff <= rx_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff   <= req_opcode;
         off_ff  <= req_reg_offset;
         data_ff <= req_data_byte;
      end
      if (cmd.execute) begin
         rsp_read_data  <= rd_in;
         rsp_tx_valid   <= txv_in;
         rsp_tx_byte    <= txb_in;
         rsp_irq        <= irq_in;
         rsp_rx_dropped <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         lcr_ff   <= 8'h00;
         mcr_ff   <= MCR_RESET;
         fcr_ff   <= 8'h00;
         scr_ff   <= 8'h00;
         msr_ff   <= MSR_RESET;
         dll_ff   <= 8'h00;
         dlm_ff   <= 8'h00;
         ier_ff   <= 4'h0;
         txp_ff   <= 1'b0;
         lf_cr_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         lcr_ff   <= lcr_in;
         mcr_ff   <= mcr_in;
         fcr_ff   <= fcr_in;
         scr_ff   <= scr_in;
         msr_ff   <= msr_in;
         dll_ff   <= dll_in;
         dlm_ff   <= dlm_in;
         ier_ff   <= ier_in;
         txp_ff   <= txp_in;
         lf_cr_ff <= lf_cr_in;
      end
   end

endmodule

// ===== rtl/u16550_ctrl.sv =====
// Controller: item sequencing and result valid flag.
module u16550_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output u16550_pkg::ctl_cmd_type  cmd
);
   import u16550_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff == ST_EXEC;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cmd.load_item = 1'b0;
      cmd.execute   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               cmd.execute = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (cmd.execute)          rsp_valid_in = 1'b1;
      else if (!rsp_stall)      rsp_valid_in = 1'b0;
      else                      rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_exec_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while stalled");
   a_load_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |=> (state_ff == ST_EXEC))
      else $error("captured item not processed");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_item && cmd.execute))
      else $error("load and execute in one cycle");
   a_exec_gives_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_valid_ff)
      else $error("executed item produced no transfer");

endmodule

// ===== rtl/uart_16550_register_model_unit.sv =====
// Top level of the 16550-style UART register block.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | opcode, reg_offset, data_byte
//   rsp     | out       | rsp_valid/rsp_stall  | read_data, tx_*, irq, rx_dropped
//   csr     | in        | csr_wr_en            | csr_wr_data (lf_to_cr)
//
// Each item is first captured, then executed against the registers and
// the RX FIFO memory, whose registered read port calls for the capture step.
// Synchronous active-high reset; FIFO storage is not cleared.
// A stalled rsp holds the execute cycle; a new item is taken while a result waits.
module uart_16550_register_model_unit #(
   parameter int RX_FIFO_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [2:0] req_reg_offset,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_irq,
   output logic       rsp_rx_dropped,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import u16550_pkg::*;

   ctl_cmd_type cmd;

   u16550_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   u16550_dpath #(
      .RX_FIFO_DEPTH (RX_FIFO_DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_opcode     (req_opcode),
      .req_reg_offset (req_reg_offset),
      .req_data_byte  (req_data_byte),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_read_data  (rsp_read_data),
      .rsp_tx_valid   (rsp_tx_valid),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_irq        (rsp_irq),
      .rsp_rx_dropped (rsp_rx_dropped)
   );

endmodule
